>>> hw/rtl/ipv4wc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4wc_pkg
// Shared types and constants for the IPv4 wildcard address checker.
// ----------------------------------------------------------------------------
package ipv4wc_pkg;

	// Characters of interest
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// Character classes decided by the front end
	localparam logic [1:0] CLS_DOT   = 2'd0;
	localparam logic [1:0] CLS_STAR  = 2'd1;
	localparam logic [1:0] CLS_DIGIT = 2'd2;
	localparam logic [1:0] CLS_OTHER = 2'd3;

	// Segment rules
	localparam int          DOTS_W        = 3;
	localparam int          LEN_W         = 3;
	localparam int          VAL_W         = 9;
	localparam int          PROD_W        = 12;
	localparam logic [VAL_W-1:0]  SEG_MAX_VALUE = 9'd255;
	localparam logic [VAL_W-1:0]  SEG_SAT_VALUE = 9'd256;
	localparam logic [PROD_W-1:0] SEG_SAT_WIDE  = 12'd256;
	localparam logic [LEN_W-1:0]  LEN_SAT       = 3'd7;
	localparam logic [DOTS_W-1:0] DOTS_SAT      = 3'd7;
	localparam logic [DOTS_W-1:0] DOTS_NEEDED   = 3'd3;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0] cls;
		logic [3:0] digit;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

>>> hw/rtl/ipv4wc_front.sv
// ----------------------------------------------------------------------------
// ipv4wc_front
// Accepts characters and classifies each one into dot, wildcard, digit or
// other, pushing the result into the queue.
// ----------------------------------------------------------------------------
module ipv4wc_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            char_byte,
	input  logic                  end_of_string,
	input  ipv4wc_pkg::q_status_t q_status,
	output logic                  push,
	output ipv4wc_pkg::q_entry_t  push_entry
);
	import ipv4wc_pkg::*;

	logic [7:0] diff;

	// Hold off the source while the queue has no room
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Digit value, meaningful only for the digit class
	assign diff = char_byte - CHAR_ZERO;

	// Character classification
	always_comb begin
		push_entry.last  = end_of_string;
		push_entry.digit = diff[3:0];
		if (char_byte == CHAR_DOT) begin
			push_entry.cls = CLS_DOT;
		end else if (char_byte == CHAR_STAR) begin
			push_entry.cls = CLS_STAR;
		end else if (char_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
			push_entry.cls = CLS_DIGIT;
		end else begin
			push_entry.cls = CLS_OTHER;
		end
	end

endmodule

>>> hw/rtl/ipv4wc_queue.sv
// ----------------------------------------------------------------------------
// ipv4wc_queue
// Short register queue decoupling the classifier from the segment checker.
// ----------------------------------------------------------------------------
module ipv4wc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ipv4wc_pkg::q_entry_t  push_entry,
	input  logic                  pop,
	output ipv4wc_pkg::q_entry_t  head,
	output ipv4wc_pkg::q_status_t status
);
	import ipv4wc_pkg::*;

	q_entry_t           entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign head             = entries_q[rd_ptr_q];
	assign status.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/ipv4wc_back.sv
// ----------------------------------------------------------------------------
// ipv4wc_back
// Segment checker: tracks dots, segment length, value and flags, and on the
// last character registers the verdict for the output channel.
// ----------------------------------------------------------------------------
module ipv4wc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4wc_pkg::q_entry_t  head,
	input  ipv4wc_pkg::q_status_t q_status,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  address_ok
);
	import ipv4wc_pkg::*;

	logic [DOTS_W-1:0] dots_q;
	logic [LEN_W-1:0]  len_q;
	logic [VAL_W-1:0]  val_q;
	logic              wild_q;
	logic              lz_q;
	logic              fail_q;
	logic              out_valid_q;
	logic              ok_q;

	logic [DOTS_W-1:0] n_dots;
	logic [LEN_W-1:0]  n_len;
	logic [VAL_W-1:0]  n_val;
	logic              n_wild;
	logic              n_lz;
	logic              n_fail;
	logic [LEN_W-1:0]  len_bump;
	logic [PROD_W-1:0] prod;
	logic              cur_good;
	logic              n_good;
	logic              verdict;
	logic              out_free;

	// Output slot can take a verdict when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = q_status.not_empty && (!head.last || out_free);

	assign len_bump = (len_q < LEN_SAT) ? len_q + 1'b1 : len_q;
	assign prod     = ({3'b000, val_q} << 3) + ({3'b000, val_q} << 1)
	                  + {8'h00, head.digit};
	assign cur_good = (len_q != '0) && (wild_q || (val_q <= SEG_MAX_VALUE));

	// Per-character state update
	always_comb begin
		n_dots = dots_q;
		n_len  = len_q;
		n_val  = val_q;
		n_wild = wild_q;
		n_lz   = lz_q;
		n_fail = fail_q;
		case (head.cls)
			CLS_DOT: begin
				if (!cur_good) begin
					n_fail = 1'b1;
				end
				if (dots_q < DOTS_SAT) begin
					n_dots = dots_q + 1'b1;
				end
				n_len  = '0;
				n_val  = '0;
				n_wild = 1'b0;
				n_lz   = 1'b0;
			end
			CLS_STAR: begin
				if (len_q != '0) begin
					n_fail = 1'b1;
				end
				n_wild = 1'b1;
				n_len  = len_bump;
			end
			CLS_DIGIT: begin
				if (wild_q || (len_q != '0 && lz_q)) begin
					n_fail = 1'b1;
				end
				if (len_q == '0 && head.digit == 4'd0) begin
					n_lz = 1'b1;
				end
				n_val = (prod > SEG_SAT_WIDE) ? SEG_SAT_VALUE : prod[VAL_W-1:0];
				n_len = len_bump;
			end
			default: begin
				n_fail = 1'b1;
			end
		endcase
	end

	// Verdict on the state after this character
	assign n_good  = (n_len != '0) && (n_wild || (n_val <= SEG_MAX_VALUE));
	assign verdict = !n_fail && n_good && (n_dots == DOTS_NEEDED);

	// String state, cleared after every verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dots_q <= '0;
			len_q  <= '0;
			val_q  <= '0;
			wild_q <= 1'b0;
			lz_q   <= 1'b0;
			fail_q <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				dots_q <= '0;
				len_q  <= '0;
				val_q  <= '0;
				wild_q <= 1'b0;
				lz_q   <= 1'b0;
				fail_q <= 1'b0;
			end else begin
				dots_q <= n_dots;
				len_q  <= n_len;
				val_q  <= n_val;
				wild_q <= n_wild;
				lz_q   <= n_lz;
				fail_q <= n_fail;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			ok_q <= verdict;
		end
	end

	assign out_valid  = out_valid_q;
	assign address_ok = ok_q;

endmodule

>>> hw/rtl/ipv4_wildcard_address_checker.sv
// ----------------------------------------------------------------------------
// ipv4_wildcard_address_checker
// Checks a dotted-quad IPv4 string, one character per transaction, with
// '*' wildcard segments; one verdict per string on its last character.
// out_valid is registered when the checker pops the last character.
// Throughput: one character per cycle while in_stall is low (queue not full).
// A two-entry queue parts classifier from checker; the output register skids.
// Reset (arst_n low, asynchronous) empties the queue and clears string state.
// ----------------------------------------------------------------------------
module ipv4_wildcard_address_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       address_ok
);
	import ipv4wc_pkg::*;

	q_status_t q_status;
	q_entry_t  push_entry;
	q_entry_t  q_head;
	logic      push;
	logic      q_pop;

	// Classifier
	ipv4wc_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_byte     (char_byte),
		.end_of_string (end_of_string),
		.q_status      (q_status),
		.push          (push),
		.push_entry    (push_entry)
	);

	// Decoupling queue
	ipv4wc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.status     (q_status)
	);

	// Segment checker and output register
	ipv4wc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.q_status   (q_status),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.address_ok (address_ok)
	);

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_status.not_empty)
		else $error("queue popped while empty");

	// A full queue cannot be empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && !q_status.not_empty))
		else $error("queue status inconsistent");

	// A new verdict only follows the pop of a last character
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop && q_head.last))
		else $error("verdict without end of string");

endmodule
